FILE: hdl/zhr_pkg.sv
// Shared constants, codes and controller/datapath link types for the zone heat-map refresh.
// No dependencies; the RTL files refer to this package by scoped names, the testbench imports it.

package zhr_pkg;

   // Array geometry and field widths
   localparam int ZONE_COUNT      = 64;
   localparam int DISTANCE_BITS   = 12;
   localparam int ZONE_INDEX_BITS = 6;
   localparam int ZONE_BITS       = $clog2(ZONE_COUNT);
   localparam int COUNT_BITS      = $clog2(ZONE_COUNT + 1);
   localparam int SUM_BITS        = DISTANCE_BITS + ZONE_BITS;
   localparam int DIV_STEP_BITS   = $clog2(SUM_BITS + 1);
   localparam int COLOUR_BITS     = 16;
   localparam int THR_BITS        = 8;
   localparam int NUM_BITS        = 16;
   localparam int RECIP_BITS      = 32;
   localparam int QUOT_BITS       = 6;

   localparam logic [SUM_BITS-1:0] SUM_LIMIT =
      SUM_BITS'(((1 << DISTANCE_BITS) - 1) * ZONE_COUNT);

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CELL_THR   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AVG_THR    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FAR_COLOUR = 2'd2;

   localparam logic [THR_BITS-1:0]    CELL_THR_RESET   = 8'd5;
   localparam logic [THR_BITS-1:0]    AVG_THR_RESET    = 8'd5;
   localparam logic [COLOUR_BITS-1:0] FAR_COLOUR_RESET = 16'd992;

   // Request and result codes
   localparam logic CMD_SAMPLE  = 1'b0;
   localparam logic CMD_RESTART = 1'b1;
   localparam logic KIND_CELL   = 1'b0;
   localparam logic KIND_AVG    = 1'b1;

   // Heat colour ramp
   localparam logic [COLOUR_BITS-1:0] COLOUR_NO_READING = 16'h2104;
   localparam logic [COLOUR_BITS-1:0] COLOUR_NEAR       = 16'hF800;
   localparam logic [COLOUR_BITS-1:0] RED_FULL          = 16'(31 << 11);
   localparam logic [COLOUR_BITS-1:0] GREEN_FULL        = 16'(63 << 5);
   localparam int RED_SHIFT   = 11;
   localparam int GREEN_SHIFT = 5;
   localparam logic [COLOUR_BITS-1:0] RISE_HIGH_BASE = 16'd20;

   localparam logic [NUM_BITS-1:0] BAND_NEAR = 16'd300;
   localparam logic [NUM_BITS-1:0] BAND_MID  = 16'd600;
   localparam logic [NUM_BITS-1:0] BAND_HIGH = 16'd1200;
   localparam logic [NUM_BITS-1:0] BAND_FAR  = 16'd2500;

   // Reciprocals ceil(2^32 / D); exact for the numerators the ramp produces
   localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP_300  = RECIP_BITS'((RECIP_ONE + 64'd299) / 64'd300);
   localparam logic [RECIP_BITS-1:0] RECIP_600  = RECIP_BITS'((RECIP_ONE + 64'd599) / 64'd600);
   localparam logic [RECIP_BITS-1:0] RECIP_1300 =
      RECIP_BITS'((RECIP_ONE + 64'd1299) / 64'd1300);

   // Colour band of a distance
   localparam int RGN_BITS = 3;
   localparam logic [RGN_BITS-1:0] RGN_NONE      = 3'd0;
   localparam logic [RGN_BITS-1:0] RGN_NEAR      = 3'd1;
   localparam logic [RGN_BITS-1:0] RGN_RISE_LOW  = 3'd2;
   localparam logic [RGN_BITS-1:0] RGN_RISE_HIGH = 3'd3;
   localparam logic [RGN_BITS-1:0] RGN_FALL      = 3'd4;
   localparam logic [RGN_BITS-1:0] RGN_FAR       = 3'd5;

   // Controller to datapath
   typedef struct packed {
      logic capture;    // request taken, latch it and read the zone store
      logic restart;    // forget all drawn distances and the average
      logic update;     // compare, write back, accumulate
      logic colour;     // reciprocal multiply, form the colour
      logic average;    // judge the frame mean
      logic emit_cell;
      logic emit_avg;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic restart_item;
      logic zone_ok;
      logic last_zone;
      logic cell_hit;
      logic cell_hit_ff;
      logic avg_hit;
      logic avg_hit_ff;
      logic div_busy;
      logic out_free;
   } dp_status_type;

endpackage

FILE: hdl/zone_heatmap_refresh.sv
// Zone heat-map refresh: top level joining the sequencer and the datapath.
// A cell update is registered after the colour step (on the last zone, also after the mean
// divider); the frame mean follows the mean divider on the last zone, behind any cell update.
// The sequencer works on one request at a time and takes no new request until the last is
// through; the mean divider and a stalled result channel can keep it busy for longer.
// Reset (synchronous): thresholds 5 mm, far colour 992, every zone undrawn, no mean shown.

module zone_heatmap_refresh (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_cmd,
   input  logic [zhr_pkg::ZONE_INDEX_BITS-1:0]    req_zone_index,
   input  logic [zhr_pkg::DISTANCE_BITS-1:0]      req_distance_mm,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_update_kind,
   output logic [zhr_pkg::ZONE_INDEX_BITS-1:0]    rsp_cell_zone,
   output logic [zhr_pkg::COLOUR_BITS-1:0]        rsp_cell_colour,
   output logic [zhr_pkg::DISTANCE_BITS-1:0]      rsp_frame_average_mm,
   output logic                                   rsp_last_of_run,
   // configuration
   input  logic                                   csr_wr_en,
   input  logic [zhr_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [zhr_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   // The sequencer takes a request only when idle; each request walks
   //   lookup -> (colour multiply) -> (mean divide, judge) -> cell -> mean
   // skipping the steps it does not need. The zone store is read as the
   // request is taken, so the lookup step already sees the drawn distance.
   // Undrawn zones (after reset or restart) are tracked by one flag per zone,
   // all cleared together, and compare as -1.
   // The result register sits between the sequencer and the result channel,
   // so a stalled result only holds the sequencer when a second result is due.

   zhr_pkg::ctrl_cmd_type  cmd;
   zhr_pkg::dp_status_type status;

   zhr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   zhr_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_cmd              (req_cmd),
      .req_zone_index       (req_zone_index),
      .req_distance_mm      (req_distance_mm),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_update_kind      (rsp_update_kind),
      .rsp_cell_zone        (rsp_cell_zone),
      .rsp_cell_colour      (rsp_cell_colour),
      .rsp_frame_average_mm (rsp_frame_average_mm),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule

FILE: hdl/zhr_div.sv
// Restoring divider for the frame mean, one quotient bit per cycle.
// Depends on zhr_pkg.

module zhr_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [zhr_pkg::SUM_BITS-1:0]    dividend,
   input  logic [zhr_pkg::COUNT_BITS-1:0]  divisor,
   output logic                            busy,
   output logic [zhr_pkg::SUM_BITS-1:0]    quotient
);

   logic                                busy_ff, busy_in;
   logic [zhr_pkg::DIV_STEP_BITS-1:0]   step_ff, step_in;
   logic [zhr_pkg::COUNT_BITS:0]        rem_ff, rem_in;
   logic [zhr_pkg::SUM_BITS-1:0]        quo_ff, quo_in;
   logic [zhr_pkg::COUNT_BITS-1:0]      den_ff, den_in;
   logic [zhr_pkg::COUNT_BITS:0]        shifted;
   logic                                fits;

   assign shifted = {rem_ff[zhr_pkg::COUNT_BITS-1:0], quo_ff[zhr_pkg::SUM_BITS-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = zhr_pkg::DIV_STEP_BITS'(zhr_pkg::SUM_BITS);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? shifted - {1'b0, den_ff} : shifted;
         quo_in  = {quo_ff[zhr_pkg::SUM_BITS-2:0], fits};
         step_in = step_ff - 1'b1;
         busy_in = step_ff != zhr_pkg::DIV_STEP_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted mid-run");

   a_step_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff != '0)
      else $error("divider busy with no steps left");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && den_ff != '0) |-> rem_ff < {1'b0, den_ff})
      else $error("partial remainder not below divisor");

endmodule

FILE: hdl/zhr_dp.sv
// Datapath: zone store, colour ramp, frame accumulators, mean divider, result register.
// Depends on zhr_pkg and zhr_div.

module zhr_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  zhr_pkg::ctrl_cmd_type                  cmd,
   output zhr_pkg::dp_status_type                 status,
   input  logic                                   req_cmd,
   input  logic [zhr_pkg::ZONE_INDEX_BITS-1:0]    req_zone_index,
   input  logic [zhr_pkg::DISTANCE_BITS-1:0]      req_distance_mm,
   input  logic                                   csr_wr_en,
   input  logic [zhr_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [zhr_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_update_kind,
   output logic [zhr_pkg::ZONE_INDEX_BITS-1:0]    rsp_cell_zone,
   output logic [zhr_pkg::COLOUR_BITS-1:0]        rsp_cell_colour,
   output logic [zhr_pkg::DISTANCE_BITS-1:0]      rsp_frame_average_mm,
   output logic                                   rsp_last_of_run
);

   localparam int DB = zhr_pkg::DISTANCE_BITS;

   // configuration
   logic [zhr_pkg::THR_BITS-1:0]    cell_thr_ff, avg_thr_ff;
   logic [zhr_pkg::COLOUR_BITS-1:0] far_colour_ff;

   // latched request and zone store read
   logic                                item_cmd_ff;
   logic [zhr_pkg::ZONE_INDEX_BITS-1:0] item_zone_ff;
   logic [DB-1:0]                       item_dist_ff;
   logic [DB-1:0]                       dist_mem [zhr_pkg::ZONE_COUNT];
   logic [DB-1:0]                       stored_ff;
   logic [zhr_pkg::ZONE_COUNT-1:0]      drawn_ff;
   logic                                seen_ff;
   logic [zhr_pkg::ZONE_BITS-1:0]       rd_addr, wr_addr;

   // compare and ramp
   logic [DB:0]                         cell_diff;
   logic                                cell_hit;
   logic [zhr_pkg::NUM_BITS-1:0]        dist_ext, num_in, num_ff, base;
   logic [zhr_pkg::RGN_BITS-1:0]        region_in, region_ff;
   logic [zhr_pkg::RECIP_BITS-1:0]      recip;
   logic [zhr_pkg::NUM_BITS+zhr_pkg::RECIP_BITS-1:0] product;
   logic [zhr_pkg::COLOUR_BITS-1:0]     quot, colour_in, colour_ff;
   logic                                cell_hit_ff;

   // frame accumulators and mean
   logic [zhr_pkg::SUM_BITS-1:0]        sum_ff, sum_in, dist_wide;
   logic [zhr_pkg::COUNT_BITS-1:0]      count_ff, count_in, frame_count_ff;
   logic                                last_zone, zone_ok, div_start, div_busy;
   logic [zhr_pkg::SUM_BITS-1:0]        div_quo;
   logic [DB-1:0]                       avg_value, shown_avg_ff;
   logic                                shown_avg_valid_ff;
   logic [DB:0]                         avg_diff;
   logic                                avg_hit, avg_hit_ff;

   // result register
   logic                                rsp_valid_ff, out_free;
   logic                                rsp_kind_ff, rsp_last_ff;
   logic [zhr_pkg::ZONE_INDEX_BITS-1:0] rsp_zone_ff;
   logic [zhr_pkg::COLOUR_BITS-1:0]     rsp_colour_ff;
   logic [DB-1:0]                       rsp_avg_ff;

   // ---------------- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_thr_ff   <= zhr_pkg::CELL_THR_RESET;
         avg_thr_ff    <= zhr_pkg::AVG_THR_RESET;
         far_colour_ff <= zhr_pkg::FAR_COLOUR_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            zhr_pkg::CSR_CELL_THR:   cell_thr_ff   <= csr_wdata[zhr_pkg::THR_BITS-1:0];
            zhr_pkg::CSR_AVG_THR:    avg_thr_ff    <= csr_wdata[zhr_pkg::THR_BITS-1:0];
            zhr_pkg::CSR_FAR_COLOUR: far_colour_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- request latch and zone store
   assign rd_addr = zhr_pkg::ZONE_BITS'(req_zone_index);
   assign wr_addr = zhr_pkg::ZONE_BITS'(item_zone_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_cmd_ff  <= req_cmd;
         item_zone_ff <= req_zone_index;
         item_dist_ff <= req_distance_mm;
         stored_ff    <= dist_mem[rd_addr];
         seen_ff      <= drawn_ff[rd_addr];
      end
      if (cmd.update && cell_hit) begin
         dist_mem[wr_addr] <= item_dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         drawn_ff <= '0;
      end else if (cmd.update && cell_hit) begin
         drawn_ff[wr_addr] <= 1'b1;
      end
   end

   assign zone_ok   = 32'(item_zone_ff) < 32'(zhr_pkg::ZONE_COUNT);
   assign last_zone = 32'(item_zone_ff) == 32'(zhr_pkg::ZONE_COUNT - 1);

   // undrawn zone behaves as -1
   always_comb begin
      if (!seen_ff) begin
         cell_diff = {1'b0, item_dist_ff} + 1'b1;
      end else if (item_dist_ff >= stored_ff) begin
         cell_diff = {1'b0, item_dist_ff - stored_ff};
      end else begin
         cell_diff = {1'b0, stored_ff - item_dist_ff};
      end
   end
   assign cell_hit = cell_diff > (DB+1)'(cell_thr_ff);

   // ---------------- colour band and numerator (shift-add constants)
   assign dist_ext = zhr_pkg::NUM_BITS'(item_dist_ff);

   always_comb begin
      base      = '0;
      num_in    = '0;
      region_in = zhr_pkg::RGN_FAR;
      if (dist_ext == '0) begin
         region_in = zhr_pkg::RGN_NONE;
      end else if (dist_ext < zhr_pkg::BAND_NEAR) begin
         region_in = zhr_pkg::RGN_NEAR;
      end else if (dist_ext < zhr_pkg::BAND_MID) begin
         region_in = zhr_pkg::RGN_RISE_LOW;
         base      = dist_ext - zhr_pkg::BAND_NEAR;
         num_in    = (base << 4) + (base << 2);                  // x20
      end else if (dist_ext < zhr_pkg::BAND_HIGH) begin
         region_in = zhr_pkg::RGN_RISE_HIGH;
         base      = dist_ext - zhr_pkg::BAND_MID;
         num_in    = (base << 5) + (base << 3) + (base << 1) + base;  // x43
      end else if (dist_ext < zhr_pkg::BAND_FAR) begin
         region_in = zhr_pkg::RGN_FALL;
         base      = zhr_pkg::BAND_FAR - dist_ext;
         num_in    = (base << 5) - base;                           // x31
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         num_ff      <= num_in;
         region_ff   <= region_in;
         cell_hit_ff <= cell_hit;
      end
   end

   // ---------------- reciprocal multiply and colour assembly
   always_comb begin
      case (region_ff)
         zhr_pkg::RGN_RISE_LOW:  recip = zhr_pkg::RECIP_300;
         zhr_pkg::RGN_RISE_HIGH: recip = zhr_pkg::RECIP_600;
         default:                recip = zhr_pkg::RECIP_1300;
      endcase
   end

   assign product = zhr_pkg::NUM_BITS'(num_ff) * recip;
   assign quot    = zhr_pkg::COLOUR_BITS'(product[zhr_pkg::RECIP_BITS +: zhr_pkg::QUOT_BITS]);

   always_comb begin
      case (region_ff)
         zhr_pkg::RGN_NONE:      colour_in = zhr_pkg::COLOUR_NO_READING;
         zhr_pkg::RGN_NEAR:      colour_in = zhr_pkg::COLOUR_NEAR;
         zhr_pkg::RGN_RISE_LOW:  colour_in = zhr_pkg::RED_FULL | (quot << zhr_pkg::GREEN_SHIFT);
         zhr_pkg::RGN_RISE_HIGH: colour_in = zhr_pkg::RED_FULL |
                                    ((quot + zhr_pkg::RISE_HIGH_BASE) << zhr_pkg::GREEN_SHIFT);
         zhr_pkg::RGN_FALL:      colour_in = (quot << zhr_pkg::RED_SHIFT) | zhr_pkg::GREEN_FULL;
         default:                colour_in = far_colour_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.colour) begin
         colour_ff <= colour_in;
      end
   end

   // ---------------- frame accumulators (saturating)
   assign dist_wide = zhr_pkg::SUM_BITS'(item_dist_ff);

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (item_dist_ff != '0) begin
         sum_in = (zhr_pkg::SUM_LIMIT - sum_ff < dist_wide) ? zhr_pkg::SUM_LIMIT
                                                             : sum_ff + dist_wide;
         if (32'(count_ff) < 32'(zhr_pkg::ZONE_COUNT)) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   assign div_start = cmd.update && last_zone;

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.update) begin
         sum_ff   <= last_zone ? '0 : sum_in;
         count_ff <= last_zone ? '0 : count_in;
      end
      if (div_start) begin
         frame_count_ff <= count_in;
      end
   end

   zhr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (count_in),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // ---------------- frame mean against the reported one
   assign avg_value = (frame_count_ff == '0) ? '0 : div_quo[DB-1:0];

   always_comb begin
      if (!shown_avg_valid_ff) begin
         avg_diff = {1'b0, avg_value} + 1'b1;
      end else if (avg_value >= shown_avg_ff) begin
         avg_diff = {1'b0, avg_value - shown_avg_ff};
      end else begin
         avg_diff = {1'b0, shown_avg_ff - avg_value};
      end
   end
   assign avg_hit = avg_diff > (DB+1)'(avg_thr_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         shown_avg_valid_ff <= 1'b0;
         avg_hit_ff         <= 1'b0;
      end else if (cmd.update) begin
         avg_hit_ff <= 1'b0;
      end else if (cmd.average) begin
         avg_hit_ff <= avg_hit;
         if (avg_hit) begin
            shown_avg_valid_ff <= 1'b1;
         end
      end
      if (cmd.average && avg_hit) begin
         shown_avg_ff <= avg_value;
      end
   end

   // ---------------- result register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_cell || cmd.emit_avg) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit_cell) begin
         rsp_kind_ff   <= zhr_pkg::KIND_CELL;
         rsp_zone_ff   <= item_zone_ff;
         rsp_colour_ff <= colour_ff;
         rsp_avg_ff    <= '0;
         rsp_last_ff   <= !avg_hit_ff;
      end else if (cmd.emit_avg) begin
         rsp_kind_ff   <= zhr_pkg::KIND_AVG;
         rsp_zone_ff   <= '0;
         rsp_colour_ff <= '0;
         rsp_avg_ff    <= shown_avg_ff;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_update_kind      = rsp_kind_ff;
   assign rsp_cell_zone        = rsp_zone_ff;
   assign rsp_cell_colour      = rsp_colour_ff;
   assign rsp_frame_average_mm = rsp_avg_ff;
   assign rsp_last_of_run      = rsp_last_ff;

   // ---------------- status
   always_comb begin
      status              = '0;
      status.restart_item = item_cmd_ff == zhr_pkg::CMD_RESTART;
      status.zone_ok      = zone_ok;
      status.last_zone    = last_zone;
      status.cell_hit     = cell_hit;
      status.cell_hit_ff  = cell_hit_ff;
      status.avg_hit      = avg_hit;
      status.avg_hit_ff   = avg_hit_ff;
      status.div_busy     = div_busy;
      status.out_free     = out_free;
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_cell || cmd.emit_avg) |-> out_free)
      else $error("result loaded over an unclaimed result");

   a_avg_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == zhr_pkg::KIND_AVG) |-> rsp_last_ff)
      else $error("average update not flagged last");

   a_accum_bounds: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= zhr_pkg::SUM_LIMIT && 32'(count_ff) <= 32'(zhr_pkg::ZONE_COUNT))
      else $error("frame accumulator beyond saturation");

endmodule

FILE: hdl/zhr_ctrl.sv
// Sequencer for the zone heat-map refresh: one request at a time through lookup,
// colour, frame mean and result hand-off. Depends on zhr_pkg.

module zhr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  zhr_pkg::dp_status_type status,
   output zhr_pkg::ctrl_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOOK = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_AVG  = 3'd4;
   localparam logic [2:0] S_CELL = 3'd5;
   localparam logic [2:0] S_MEAN = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            if (status.restart_item) begin
               cmd.restart = 1'b1;
               state_in    = S_IDLE;
            end else if (!status.zone_ok) begin
               state_in = S_IDLE;
            end else begin
               cmd.update = 1'b1;
               if (status.cell_hit) begin
                  state_in = S_MUL;
               end else if (status.last_zone) begin
                  state_in = S_DIV;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_MUL: begin
            cmd.colour = 1'b1;
            state_in   = status.last_zone ? S_DIV : S_CELL;
         end
         S_DIV: begin
            if (!status.div_busy) begin
               state_in = S_AVG;
            end
         end
         S_AVG: begin
            cmd.average = 1'b1;
            if (status.cell_hit_ff) begin
               state_in = S_CELL;
            end else if (status.avg_hit) begin
               state_in = S_MEAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CELL: begin
            if (status.out_free) begin
               cmd.emit_cell = 1'b1;
               state_in      = status.avg_hit_ff ? S_MEAN : S_IDLE;
            end
         end
         S_MEAN: begin
            if (status.out_free) begin
               cmd.emit_avg = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

FILE: verif/tb_zone_heatmap_refresh.sv
// Self-checking testbench for zone_heatmap_refresh: directed and random zone requests
// with random idling on both channels. Depends on zhr_pkg and the RTL in hdl/.
`timescale 1ns / 100ps

module tb_zone_heatmap_refresh;
   import zhr_pkg::*;

   localparam int LONG_HOLD_CYCLES = 300;   // result side hold-off for the pressure test
   localparam int SETTLE_CYCLES    = 40;    // covers the mean divider after the last result
   localparam int DRAIN_LIMIT      = 5000;
   localparam int MAX_MM           = (1 << DISTANCE_BITS) - 1;
   localparam int SUM_CEILING      = MAX_MM * ZONE_COUNT;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct {
      logic                       kind;
      logic [ZONE_INDEX_BITS-1:0] zone;
      logic [COLOUR_BITS-1:0]     colour;
      logic [DISTANCE_BITS-1:0]   mean_mm;
      logic                       last;
   } heat_update_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_cmd;
   logic [ZONE_INDEX_BITS-1:0] req_zone_index;
   logic [DISTANCE_BITS-1:0]   req_distance_mm;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic                       rsp_update_kind;
   logic [ZONE_INDEX_BITS-1:0] rsp_cell_zone;
   logic [COLOUR_BITS-1:0]     rsp_cell_colour;
   logic [DISTANCE_BITS-1:0]   rsp_frame_average_mm;
   logic                       rsp_last_of_run;
   logic                       csr_wr_en;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_wdata;

   // Predictor state: what the block should currently have drawn and reported.
   // -1 marks a zone (or the mean) that has never been drawn since reset/restart.
   int                     drawn_mm [ZONE_COUNT];
   int                     frame_sum_mm;
   int                     frame_valid_zones;
   int                     reported_mean_mm;
   int                     cell_threshold;
   int                     mean_threshold;
   logic [COLOUR_BITS-1:0] far_colour_setting;
   heat_update_type        expected_updates [$];

   int error_count;
   int requests_sent;
   int cell_updates_seen;
   int mean_updates_seen;
   bit quiet;          // both sides run with no idling while set
   bit hold_request;   // asks the receiver for one long hold-off

   zone_heatmap_refresh u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cmd              (req_cmd),
      .req_zone_index       (req_zone_index),
      .req_distance_mm      (req_distance_mm),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_update_kind      (rsp_update_kind),
      .rsp_cell_zone        (rsp_cell_zone),
      .rsp_cell_colour      (rsp_cell_colour),
      .rsp_frame_average_mm (rsp_frame_average_mm),
      .rsp_last_of_run      (rsp_last_of_run),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   function automatic void forget_drawing();
      foreach (drawn_mm[i]) drawn_mm[i] = -1;
      frame_sum_mm      = 0;
      frame_valid_zones = 0;
      reported_mean_mm  = -1;
   endfunction

   // Red-to-green ramp; every division truncates.
   function automatic logic [COLOUR_BITS-1:0] colour_for_distance(int d);
      if (d == 0)    return COLOUR_NO_READING;
      if (d < 300)   return COLOUR_NEAR;
      if (d < 600)   return RED_FULL | 16'(((d - 300) * 20 / 300) << GREEN_SHIFT);
      if (d < 1200)  return RED_FULL | 16'((20 + (d - 600) * 43 / 600) << GREEN_SHIFT);
      if (d < 2500)  return 16'(((2500 - d) * 31 / 1300) << RED_SHIFT) | GREEN_FULL;
      return far_colour_setting;
   endfunction

   function automatic int abs_gap(int a, int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Works out the updates one accepted request must cause and queues them in order.
   function automatic void predict_request(logic cmd, logic [ZONE_INDEX_BITS-1:0] zone,
                                           logic [DISTANCE_BITS-1:0] dist_mm);
      int              d;
      int              mean;
      bit              cell_hit;
      bit              mean_hit;
      heat_update_type upd;
      d = int'(dist_mm);
      if (cmd == CMD_RESTART) begin
         forget_drawing();
         return;
      end
      cell_hit = abs_gap(d, drawn_mm[zone]) > cell_threshold;
      if (cell_hit) drawn_mm[zone] = d;
      if (d > 0) begin
         frame_sum_mm = (SUM_CEILING - frame_sum_mm < d) ? SUM_CEILING : frame_sum_mm + d;
         if (frame_valid_zones < ZONE_COUNT) frame_valid_zones++;
      end
      mean_hit = 1'b0;
      mean     = 0;
      if (zone == ZONE_COUNT - 1) begin
         mean     = (frame_valid_zones > 0) ? frame_sum_mm / frame_valid_zones : 0;
         mean_hit = abs_gap(mean, reported_mean_mm) > mean_threshold;
         if (mean_hit) reported_mean_mm = mean;
         frame_sum_mm      = 0;
         frame_valid_zones = 0;
      end
      if (cell_hit) begin
         upd.kind    = KIND_CELL;
         upd.zone    = zone;
         upd.colour  = colour_for_distance(d);
         upd.mean_mm = '0;
         upd.last    = !mean_hit;
         expected_updates.push_back(upd);
      end
      if (mean_hit) begin
         upd.kind    = KIND_AVG;
         upd.zone    = '0;
         upd.colour  = '0;
         upd.mean_mm = 12'(mean);
         upd.last    = 1'b1;
         expected_updates.push_back(upd);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Result side: random stall per result, plus one long hold-off on demand
   // ---------------------------------------------------------------------------

   initial begin : result_receiver
      int wait_cycles;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!reset && rsp_valid && !rsp_stall) begin
            wait_cycles = quiet ? 0 : $urandom_range(0, 3);
            if (wait_cycles > 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_cycles) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Every result taken is matched against the oldest outstanding expectation.
   always @(posedge clock) begin : result_checker
      heat_update_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_updates.size() == 0) begin
            $display("%0t: unexpected update kind=%0d zone=%0d colour=%h mean=%0d last=%0d",
                     $time, rsp_update_kind, rsp_cell_zone, rsp_cell_colour,
                     rsp_frame_average_mm, rsp_last_of_run);
            error_count++;
         end else begin
            want = expected_updates.pop_front();
            if (want.kind == KIND_CELL) cell_updates_seen++;
            else mean_updates_seen++;
            compare_field("update_kind", want.kind, rsp_update_kind);
            compare_field("cell_zone", want.zone, rsp_cell_zone);
            compare_field("cell_colour", want.colour, rsp_cell_colour);
            compare_field("frame_average_mm", want.mean_mm, rsp_frame_average_mm);
            compare_field("last_of_run", want.last, rsp_last_of_run);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------

   // Offers one request after a random gap and returns at the edge that takes it.
   // Valid is left high so a back-to-back request never drops it.
   task automatic send_request(logic cmd, logic [ZONE_INDEX_BITS-1:0] zone,
                               logic [DISTANCE_BITS-1:0] dist_mm);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_zone_index  <= zone;
      req_distance_mm <= dist_mm;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(cmd, zone, dist_mm);
      requests_sent++;
   endtask

   // Drops valid and waits for every outstanding result, then lets the divider finish
   // in case the last request caused none.
   task automatic settle_block();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (expected_updates.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_CELL_THR:   cell_threshold     = int'(value[THR_BITS-1:0]);
         CSR_AVG_THR:    mean_threshold     = int'(value[THR_BITS-1:0]);
         CSR_FAR_COLOUR: far_colour_setting = value;
         default: ;
      endcase
   endtask

   // Registers only change with the block idle. The unmapped index is written too
   // and must leave everything alone; upper data bits of the thresholds are junk.
   task automatic apply_settings(int cell_thr, int mean_thr, logic [COLOUR_BITS-1:0] far);
      settle_block();
      write_register(CSR_CELL_THR, {8'($urandom_range(0, 255)), 8'(cell_thr)});
      write_register(CSR_AVG_THR, {8'($urandom_range(0, 255)), 8'(mean_thr)});
      write_register(CSR_FAR_COLOUR, far);
      write_register(CSR_UNMAPPED, 16'($urandom_range(0, 65535)));
   endtask

   // Often a small move around what is drawn, so the thresholds decide often.
   function automatic logic [DISTANCE_BITS-1:0] pick_distance(logic [ZONE_INDEX_BITS-1:0] zone);
      int roll;
      int base;
      int d;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 15) return DISTANCE_BITS'(MAX_MM);
      if (roll < 55) begin
         base = (drawn_mm[zone] < 0) ? int'($urandom_range(0, MAX_MM)) : drawn_mm[zone];
         d = base + int'($urandom_range(0, 2 * cell_threshold + 4)) - (cell_threshold + 2);
         if (d < 0) d = 0;
         if (d > MAX_MM) d = MAX_MM;
         return DISTANCE_BITS'(d);
      end
      return DISTANCE_BITS'($urandom_range(0, MAX_MM));
   endfunction

   task automatic send_frame();
      for (int z = 0; z < ZONE_COUNT; z++)
         send_request(CMD_SAMPLE, 6'(z), pick_distance(6'(z)));
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Every colour band edge, the cell threshold boundary, both updates from one
   // request, a frame with no valid reading, and a restart with junk fields.
   task automatic test_directed_cases();
      int band_mm [11] = '{0, 1, 299, 300, 599, 600, 1199, 1200, 2499, 2500, 4095};
      foreach (band_mm[i]) send_request(CMD_SAMPLE, 6'(i), 12'(band_mm[i]));
      send_request(CMD_SAMPLE, 6'd11, 12'd100);
      send_request(CMD_SAMPLE, 6'd11, 12'd105);   // on the threshold: no redraw
      send_request(CMD_SAMPLE, 6'd11, 12'd106);   // just beyond: redraw
      send_request(CMD_SAMPLE, 6'd63, 12'd2000);  // cell then mean
      send_request(CMD_SAMPLE, 6'd63, 12'd0);     // no reading; mean drops to zero
      send_request(CMD_RESTART, 6'd63, 12'hFFF);
      send_request(CMD_SAMPLE, 6'd63, 12'd0);     // undrawn again: nothing reported
      settle_block();
   endtask

   task automatic test_register_extremes();
      apply_settings(0, 0, 16'hFFFF);
      send_frame();
      apply_settings(255, 255, 16'h0000);
      send_frame();
      apply_settings($urandom_range(0, 255), $urandom_range(0, 255),
                     16'($urandom_range(0, 65535)));
      send_frame();
   endtask

   // Mostly whole frames with random content; some with a restart inside, some
   // out of order, some blank, some with no idling at all.
   task automatic test_random_frames(int frames);
      int style;
      int cut;
      repeat (frames) begin
         style = $urandom_range(0, 9);
         quiet = (style >= 8);
         case (style)
            5: begin
               cut = $urandom_range(0, ZONE_COUNT - 1);
               for (int z = 0; z < ZONE_COUNT; z++) begin
                  if (z == cut)
                     send_request(CMD_RESTART, 6'($urandom_range(0, 63)),
                                  12'($urandom_range(0, MAX_MM)));
                  send_request(CMD_SAMPLE, 6'(z), pick_distance(6'(z)));
               end
            end
            6: begin
               repeat ($urandom_range(10, 40)) begin
                  cut = $urandom_range(0, ZONE_COUNT - 1);
                  send_request(CMD_SAMPLE, 6'(cut), pick_distance(6'(cut)));
               end
            end
            7: begin
               for (int z = 0; z < ZONE_COUNT; z++) send_request(CMD_SAMPLE, 6'(z), '0);
            end
            default: send_frame();
         endcase
         quiet = 1'b0;
         if ($urandom_range(0, 2) == 0)
            apply_settings($urandom_range(0, 20), $urandom_range(0, 20),
                           16'($urandom_range(0, 65535)));
      end
      settle_block();
   endtask

   // More than a frame's worth of near-full readings before the last zone, so both
   // the sum and the valid count run into their ceilings.
   task automatic test_accumulator_saturation();
      apply_settings(2, 2, FAR_COLOUR_RESET);
      repeat (70)
         send_request(CMD_SAMPLE, 6'($urandom_range(0, ZONE_COUNT - 2)),
                      12'($urandom_range(3900, MAX_MM)));
      send_request(CMD_SAMPLE, 6'(ZONE_COUNT - 1), 12'(MAX_MM));
      settle_block();
   endtask

   // Receiver holds off for a long stretch while requests keep coming back to back;
   // the block has to fill up and stall its request side.
   task automatic test_result_backpressure();
      forget_drawing();
      send_request(CMD_RESTART, '0, '0);
      quiet        = 1'b1;
      hold_request = 1'b1;
      send_frame();
      quiet = 1'b0;
      settle_block();
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_cmd         <= CMD_SAMPLE;
      req_zone_index  <= '0;
      req_distance_mm <= '0;
      csr_wr_en       <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      error_count        = 0;
      requests_sent      = 0;
      cell_updates_seen  = 0;
      mean_updates_seen  = 0;
      quiet              = 1'b0;
      hold_request       = 1'b0;
      cell_threshold     = int'(CELL_THR_RESET);
      mean_threshold     = int'(AVG_THR_RESET);
      far_colour_setting = FAR_COLOUR_RESET;
      forget_drawing();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_register_extremes();
      test_random_frames(3);
      test_accumulator_saturation();
      test_result_backpressure();

      settle_block();
      if (expected_updates.size() != 0) begin
         $display("%0t: %0d expected updates never arrived", $time, expected_updates.size());
         error_count += expected_updates.size();
      end
      $display("%0d requests, %0d cell and %0d average updates checked; colour bands,",
               requests_sent, cell_updates_seen, mean_updates_seen);
      $display("thresholds, restarts, broken order, saturation and a long result hold-off.");
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: zone_heatmap_refresh.f
hdl/zhr_pkg.sv
hdl/zhr_div.sv
hdl/zhr_dp.sv
hdl/zhr_ctrl.sv
hdl/zone_heatmap_refresh.sv
verif/tb_zone_heatmap_refresh.sv
